>>> hw/rtl/olist_pkg.sv
package olist_pkg;

	localparam int CMD_W    = 3;
	localparam int POS_W    = 6;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int RDATA_W  = 32;
	localparam int COUNT_W  = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_SEARCH = 3'd3,
		CMD_READ   = 3'd4
	} cmd_code_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_INDEX = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS_RD,
		S_INS_WR,
		S_INS_PUT,
		S_DEL_CHK,
		S_DEL_WR,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_RD_CAP,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		ASEL_COUNT,
		ASEL_POS,
		ASEL_K,
		ASEL_KM1,
		ASEL_KP1
	} addr_sel_t;

	typedef enum logic [2:0] {
		KOP_HOLD,
		KOP_COUNT,
		KOP_POS,
		KOP_ZERO,
		KOP_INC,
		KOP_DEC
	} k_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	typedef struct packed {
		logic      in_ready;
		logic      mem_we;
		logic      wdata_mem;
		addr_sel_t waddr_sel;
		addr_sel_t raddr_sel;
		k_op_t     k_op;
		cnt_op_t   cnt_op;
		logic      set_status;
		status_t   status;
		logic      load_rdata;
		logic      out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic             in_valid;
		logic [CMD_W-1:0] cmd;
		logic             full;
		logic             pos_gt_count;
		logic             pos_ge_count;
		logic             pos_eq_count;
		logic             count_zero;
		logic             k_prev_is_pos;
		logic             k_last;
		logic             match;
		logic             out_busy;
	} dp_stat_t;

endpackage

>>> hw/rtl/olist_if.sv
interface olist_req_if;
	import olist_pkg::*;

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [POS_W-1:0]   position;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output command, output position, output value, input ready);
	modport sink   (input valid, input command, input position, input value, output ready);
endinterface

interface olist_rsp_if;
	import olist_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [RDATA_W-1:0]  read_data;
	logic [COUNT_W-1:0]  entry_count;

	modport source (output valid, output status, output read_data, output entry_count, input ready);
	modport sink   (input valid, input status, input read_data, input entry_count, output ready);
endinterface

>>> hw/rtl/ordered_list_insert_delete_search_core.sv
// Ordered word list engine with append, insert, delete, search and read.
// Requests arrive on the req channel (command, position, value) and every
// request yields exactly one transaction on the rsp channel carrying status,
// read_data (nonzero only for a successful read) and entry_count.
// The list lives in a single-port-read, single-port-write memory with a
// registered read; every shift step takes one read and one write, and
// every compare step takes one read.
// Insert shifts the entries from the end down to the position one place up
// and then writes the new word; delete shifts the entries above the
// position one place down; search examines entries from the first up to
// the first match. Append, insert at the end and rejected requests finish
// at decode; read takes one memory read.
// One request is in work at a time; req.ready is high only while idle. The
// next request can be taken in the cycle after the response loads. A
// response waits in an output register, so the next request is taken while
// the receiver stalls; a finished request holds until the register frees.
// Reset clears the entry count and the response valid; list contents are
// left as they are and only entries below the count are ever used.
module ordered_list_insert_delete_search_core #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	olist_req_if.sink   req,
	olist_rsp_if.source rsp
);
	import olist_pkg::*;

	ctrl_cmd_t ctrl_cmd;
	dp_stat_t  dp_stat;

	olist_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (dp_stat),
		.cmd    (ctrl_cmd)
	);

	olist_dp #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (ctrl_cmd),
		.stat   (dp_stat)
	);

endmodule

>>> hw/rtl/olist_ctrl.sv
module olist_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  olist_pkg::dp_stat_t  stat,
	output olist_pkg::ctrl_cmd_t cmd
);
	import olist_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (stat.in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				case (stat.cmd)
					CMD_INSERT: begin
						if (!stat.pos_gt_count && !stat.full && !stat.pos_eq_count)
							state_d = S_INS_RD;
						else
							state_d = S_DONE;
					end
					CMD_DELETE: begin
						state_d = stat.pos_ge_count ? S_DONE : S_DEL_CHK;
					end
					CMD_SEARCH: begin
						state_d = stat.count_zero ? S_DONE : S_SRCH_RD;
					end
					CMD_READ: begin
						state_d = stat.pos_ge_count ? S_DONE : S_RD_CAP;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_INS_RD:   state_d = S_INS_WR;
			S_INS_WR:   state_d = stat.k_prev_is_pos ? S_INS_PUT : S_INS_RD;
			S_INS_PUT:  state_d = S_DONE;
			S_DEL_CHK:  state_d = stat.k_last ? S_DONE : S_DEL_WR;
			S_DEL_WR:   state_d = S_DEL_CHK;
			S_SRCH_RD:  state_d = S_SRCH_CMP;
			S_SRCH_CMP: begin
				if (stat.match || stat.k_last) state_d = S_DONE;
				else state_d = S_SRCH_RD;
			end
			S_RD_CAP:   state_d = S_DONE;
			S_DONE: begin
				if (!stat.out_busy) state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.waddr_sel  = ASEL_K;
		cmd.raddr_sel  = ASEL_K;
		cmd.k_op       = KOP_HOLD;
		cmd.cnt_op     = CNT_HOLD;
		cmd.status     = STAT_OK;
		case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
			end
			S_DECODE: begin
				cmd.set_status = 1'b1;
				case (stat.cmd)
					CMD_APPEND: begin
						if (stat.full) begin
							cmd.status = STAT_FULL;
						end else begin
							cmd.mem_we    = 1'b1;
							cmd.waddr_sel = ASEL_COUNT;
							cmd.cnt_op    = CNT_INC;
						end
					end
					CMD_INSERT: begin
						if (stat.pos_gt_count) begin
							cmd.status = STAT_BAD_INDEX;
						end else if (stat.full) begin
							cmd.status = STAT_FULL;
						end else if (stat.pos_eq_count) begin
							cmd.mem_we    = 1'b1;
							cmd.waddr_sel = ASEL_COUNT;
							cmd.cnt_op    = CNT_INC;
						end else begin
							cmd.set_status = 1'b0;
							cmd.k_op       = KOP_COUNT;
						end
					end
					CMD_DELETE: begin
						if (stat.pos_ge_count) begin
							cmd.status = STAT_BAD_INDEX;
						end else begin
							cmd.set_status = 1'b0;
							cmd.k_op       = KOP_POS;
						end
					end
					CMD_SEARCH: begin
						cmd.k_op = KOP_ZERO;
						if (stat.count_zero) cmd.status = STAT_NOT_FOUND;
						else cmd.set_status = 1'b0;
					end
					CMD_READ: begin
						cmd.raddr_sel = ASEL_POS;
						if (stat.pos_ge_count) cmd.status = STAT_BAD_INDEX;
						else cmd.set_status = 1'b0;
					end
					default: cmd.status = STAT_BAD_INDEX;
				endcase
			end
			S_INS_RD: begin
				cmd.raddr_sel = ASEL_KM1;
			end
			S_INS_WR: begin
				cmd.mem_we    = 1'b1;
				cmd.wdata_mem = 1'b1;
				cmd.waddr_sel = ASEL_K;
				cmd.k_op      = KOP_DEC;
			end
			S_INS_PUT: begin
				cmd.mem_we     = 1'b1;
				cmd.waddr_sel  = ASEL_POS;
				cmd.cnt_op     = CNT_INC;
				cmd.set_status = 1'b1;
			end
			S_DEL_CHK: begin
				cmd.raddr_sel = ASEL_KP1;
				if (stat.k_last) begin
					cmd.cnt_op     = CNT_DEC;
					cmd.set_status = 1'b1;
				end
			end
			S_DEL_WR: begin
				cmd.mem_we    = 1'b1;
				cmd.wdata_mem = 1'b1;
				cmd.waddr_sel = ASEL_K;
				cmd.k_op      = KOP_INC;
			end
			S_SRCH_RD: begin
				cmd.raddr_sel = ASEL_K;
			end
			S_SRCH_CMP: begin
				if (stat.match) begin
					cmd.set_status = 1'b1;
				end else if (stat.k_last) begin
					cmd.set_status = 1'b1;
					cmd.status     = STAT_NOT_FOUND;
				end else begin
					cmd.k_op = KOP_INC;
				end
			end
			S_RD_CAP: begin
				cmd.load_rdata = 1'b1;
				cmd.set_status = 1'b1;
			end
			S_DONE: begin
				cmd.out_load = !stat.out_busy;
			end
			default: ;
		endcase
	end

endmodule

>>> hw/rtl/olist_dp.sv
module olist_dp #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	olist_req_if.sink            req,
	olist_rsp_if.source          rsp,
	input  olist_pkg::ctrl_cmd_t cmd,
	output olist_pkg::dp_stat_t  stat
);
	import olist_pkg::*;

	localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [DATA_WIDTH-1:0] mem [CAPACITY];
	logic [DATA_WIDTH-1:0] mem_rd_q;

	logic [CMD_W-1:0]      cmd_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [CW-1:0]         count_q;
	logic [AW-1:0]         k_q;
	status_t               status_q;
	logic [RDATA_W-1:0]    rdata_q;

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [RDATA_W-1:0]    out_rdata_q;
	logic [COUNT_W-1:0]    out_count_q;

	logic [AW-1:0]         waddr;
	logic [AW-1:0]         raddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic [CMPW-1:0]       pos_x;
	logic [CMPW-1:0]       count_x;
	logic [CMPW-1:0]       k_x;

	function automatic logic [AW-1:0] sel_addr(addr_sel_t sel, logic [AW-1:0] k,
		logic [POS_W-1:0] pos, logic [CW-1:0] cnt);
		logic [AW-1:0] a;
		case (sel)
			ASEL_COUNT: a = AW'(cnt);
			ASEL_POS:   a = AW'(pos);
			ASEL_KM1:   a = k - AW'(1);
			ASEL_KP1:   a = k + AW'(1);
			default:    a = k;
		endcase
		return a;
	endfunction

	assign waddr   = sel_addr(cmd.waddr_sel, k_q, pos_q, count_q);
	assign raddr   = sel_addr(cmd.raddr_sel, k_q, pos_q, count_q);
	assign wdata   = cmd.wdata_mem ? mem_rd_q : word_q;
	assign pos_x   = CMPW'(pos_q);
	assign count_x = CMPW'(count_q);
	assign k_x     = CMPW'(k_q);

	always_ff @(posedge clk) begin
		if (cmd.mem_we) mem[waddr] <= wdata;
		mem_rd_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.in_ready && req.valid) begin
			cmd_q   <= req.command;
			pos_q   <= req.position;
			word_q  <= DATA_WIDTH'(req.value);
			rdata_q <= '0;
		end else if (cmd.load_rdata) begin
			rdata_q <= RDATA_W'(mem_rd_q);
		end
		if (cmd.set_status) status_q <= cmd.status;
		case (cmd.k_op)
			KOP_COUNT: k_q <= AW'(count_q);
			KOP_POS:   k_q <= AW'(pos_q);
			KOP_ZERO:  k_q <= '0;
			KOP_INC:   k_q <= k_q + AW'(1);
			KOP_DEC:   k_q <= k_q - AW'(1);
			default:   k_q <= k_q;
		endcase
		if (cmd.out_load) begin
			out_status_q <= status_q;
			out_rdata_q  <= rdata_q;
			out_count_q  <= COUNT_W'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (cmd.cnt_op)
				CNT_INC: count_q <= count_q + CW'(1);
				CNT_DEC: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	assign req.ready       = cmd.in_ready;
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.read_data   = out_rdata_q;
	assign rsp.entry_count = out_count_q;

	assign stat.in_valid      = req.valid;
	assign stat.cmd           = cmd_q;
	assign stat.full          = (count_x >= CMPW'(CAPACITY));
	assign stat.pos_gt_count  = (pos_x > count_x);
	assign stat.pos_ge_count  = (pos_x >= count_x);
	assign stat.pos_eq_count  = (pos_x == count_x);
	assign stat.count_zero    = (count_q == '0);
	assign stat.k_prev_is_pos = ((k_x - CMPW'(1)) == pos_x);
	assign stat.k_last        = ((k_x + CMPW'(1)) >= count_x);
	assign stat.match         = (mem_rd_q == word_q);
	assign stat.out_busy      = out_valid_q && !rsp.ready;

endmodule

>>> dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import olist_pkg::*;

	localparam int LIST_CAP     = 64;
	localparam int LIST_DW      = 32;
	localparam int HOLD_CYCLES  = 250;
	localparam int IDLE_LIMIT   = 5000;
	localparam int DRAIN_CYCLES = 300;
	localparam int RANDOM_ITEMS = 750;

	localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_W'(CMD_READ + 1);
	localparam logic [CMD_W-1:0] CMD_LAST_CODE    = {CMD_W{1'b1}};

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [POS_W-1:0]   position;
		logic [VALUE_W-1:0] value;
	} olist_req_t;

	typedef struct packed {
		status_t            status;
		logic [RDATA_W-1:0] read_data;
		logic [COUNT_W-1:0] entry_count;
	} olist_rsp_t;

	typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

	logic clk;
	logic arst_n;

	olist_req_if req_ch();
	olist_rsp_if rsp_ch();

	ordered_list_insert_delete_search_core #(
		.CAPACITY   (LIST_CAP),
		.DATA_WIDTH (LIST_DW)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [LIST_DW-1:0] list_mem [LIST_CAP];
	int                 list_count;
	int                 peak_count;

	olist_req_t pending_req_q [$];
	olist_rsp_t expected_rsp_q [$];

	int  mismatch_cnt;
	int  req_cnt;
	int  rsp_cnt;
	int  status_seen [4];
	bit  quiet_mode;
	int  pressure_ask;
	int  pressure_done;
	int  gap_left;
	int  hold_left;
	int  stall_left;
	int  idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic olist_rsp_t list_apply(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
			logic [VALUE_W-1:0] val);
		olist_rsp_t r;
		int p;
		int k;
		p = int'(pos);
		r.status = STAT_OK;
		r.read_data = '0;
		case (cmd)
			CMD_APPEND: begin
				if (list_count >= LIST_CAP) begin
					r.status = STAT_FULL;
				end else begin
					list_mem[list_count] = val;
					list_count++;
				end
			end
			CMD_INSERT: begin
				if (p > list_count) begin
					r.status = STAT_BAD_INDEX;
				end else if (list_count >= LIST_CAP) begin
					r.status = STAT_FULL;
				end else begin
					for (k = list_count; k > p; k--)
						list_mem[k] = list_mem[k-1];
					list_mem[p] = val;
					list_count++;
				end
			end
			CMD_DELETE: begin
				if (p >= list_count) begin
					r.status = STAT_BAD_INDEX;
				end else begin
					for (k = p; k + 1 < list_count; k++)
						list_mem[k] = list_mem[k+1];
					list_count--;
				end
			end
			CMD_SEARCH: begin
				r.status = STAT_NOT_FOUND;
				for (k = 0; k < list_count; k++)
					if (list_mem[k] == val)
						r.status = STAT_OK;
			end
			CMD_READ: begin
				if (p < list_count)
					r.read_data = list_mem[p];
				else
					r.status = STAT_BAD_INDEX;
			end
			default: r.status = STAT_BAD_INDEX;
		endcase
		if (list_count > peak_count)
			peak_count = list_count;
		r.entry_count = list_count[COUNT_W-1:0];
		return r;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatch_cnt++;
	endtask

	task automatic queue_req(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
			logic [VALUE_W-1:0] val);
		olist_req_t item;
		item.command = cmd;
		item.position = pos;
		item.value = val;
		pending_req_q = {pending_req_q, item};
	endtask

	task automatic queue_random(mix_t mix);
		int r;
		int n;
		logic [CMD_W-1:0]   cmd;
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] val;
		r = $urandom_range(0, 99);
		n = list_count;
		if (r < 5)
			cmd = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
		else if (mix == MIX_GROW)
			cmd = r < 45 ? CMD_APPEND : r < 80 ? CMD_INSERT : r < 87 ? CMD_DELETE :
				r < 94 ? CMD_SEARCH : CMD_READ;
		else if (mix == MIX_SHRINK)
			cmd = r < 55 ? CMD_DELETE : r < 60 ? CMD_APPEND : r < 65 ? CMD_INSERT :
				r < 82 ? CMD_SEARCH : CMD_READ;
		else
			cmd = r < 24 ? CMD_APPEND : r < 43 ? CMD_INSERT : r < 62 ? CMD_DELETE :
				r < 81 ? CMD_SEARCH : CMD_READ;

		if ($urandom_range(0, 99) < 15)
			pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
		else if (cmd == CMD_INSERT)
			pos = POS_W'($urandom_range(0, n < (1 << POS_W) ? n : (1 << POS_W) - 1));
		else if (n > 0)
			pos = POS_W'($urandom_range(0, n - 1));
		else
			pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));

		r = $urandom_range(0, 99);
		if (cmd == CMD_SEARCH && n > 0 && r < 60)
			val = list_mem[$urandom_range(0, n - 1)];
		else if (r < 70)
			val = $urandom();
		else if (r < 85)
			val = '0;
		else
			val = '1;
		queue_req(cmd, pos, val);
	endtask

	task automatic run_phase(mix_t mix, int items, bit quiet, bit squeeze);
		quiet_mode = quiet;
		if (squeeze)
			pressure_ask++;
		repeat (items) begin
			while (pending_req_q.size() >= 4)
				@(negedge clk);
			queue_random(mix);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.command <= '0;
			req_ch.position <= '0;
			req_ch.value <= '0;
			gap_left = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				olist_rsp_t exp_rsp;
				exp_rsp = list_apply(req_ch.command, req_ch.position, req_ch.value);
				expected_rsp_q = {expected_rsp_q, exp_rsp};
				req_cnt++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_ch.valid <= 1'b0;
				end else if (pending_req_q.size() > 0) begin
					olist_req_t item;
					item = pending_req_q.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.command <= item.command;
					req_ch.position <= item.position;
					req_ch.value <= item.value;
					gap_left = (!quiet_mode && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left = 0;
			stall_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_cnt++;
				status_seen[rsp_ch.status]++;
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("response with nothing pending", 32'(rsp_ch.status), 0);
				end else begin
					olist_rsp_t want;
					want = expected_rsp_q.pop_front();
					if (rsp_ch.status !== want.status)
						report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
					if (rsp_ch.read_data !== want.read_data)
						report_mismatch("read_data", rsp_ch.read_data, want.read_data);
					if (rsp_ch.entry_count !== want.entry_count)
						report_mismatch("entry_count", 32'(rsp_ch.entry_count),
							32'(want.entry_count));
				end
			end
			if (pressure_ask != pressure_done) begin
				pressure_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!quiet_mode && $urandom_range(0, 99) < 25) begin
				stall_left = pick_gap() - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles, %0d responses outstanding",
					IDLE_LIMIT, expected_rsp_q.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		list_count = 0;
		peak_count = 0;
		mismatch_cnt = 0;
		req_cnt = 0;
		rsp_cnt = 0;
		status_seen = '{default: 0};
		quiet_mode = 1'b0;
		pressure_ask = 0;
		pressure_done = 0;
		idle_cycles = 0;

		queue_req(CMD_READ,   '0, '0);
		queue_req(CMD_DELETE, '0, '0);
		queue_req(CMD_SEARCH, '0, '0);
		queue_req(CMD_INSERT, 6'd1, 32'hDEAD_BEEF);
		queue_req(CMD_INSERT, '0, '1);
		queue_req(CMD_APPEND, '1, '0);
		queue_req(CMD_APPEND, '0, 32'h8000_0001);
		queue_req(CMD_INSERT, 6'd3, 32'h5A5A_5A5A);
		queue_req(CMD_INSERT, 6'd5, 32'h0000_0001);
		queue_req(CMD_INSERT, 6'd1, 32'h1234_5678);
		for (int i = 0; i <= 5; i++)
			queue_req(CMD_READ, POS_W'(i), '1);
		queue_req(CMD_SEARCH, '0, '1);
		queue_req(CMD_SEARCH, '0, 32'h5A5A_5A5A);
		queue_req(CMD_SEARCH, '0, 32'h0000_0001);
		queue_req(CMD_DELETE, 6'd4, '0);
		queue_req(CMD_DELETE, '0, '0);
		queue_req(CMD_DELETE, '1, '0);
		for (int c = CMD_FIRST_UNUSED; c <= CMD_LAST_CODE; c++)
			queue_req(CMD_W'(c), '1, '1);
		queue_req(CMD_READ, '1, '0);

		run_phase(MIX_GROW,   150, 1'b1, 1'b0);
		run_phase(MIX_EVEN,   100, 1'b0, 1'b0);
		run_phase(MIX_SHRINK, 150, 1'b0, 1'b0);
		run_phase(MIX_GROW,   120, 1'b0, 1'b1);
		run_phase(MIX_EVEN,   120, 1'b1, 1'b0);
		run_phase(MIX_SHRINK, RANDOM_ITEMS - 640, 1'b0, 1'b1);

		while (pending_req_q.size() != 0 || req_ch.valid)
			@(negedge clk);
		while (expected_rsp_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Ran %0d requests and %0d responses, peak list length %0d of %0d",
			req_cnt, rsp_cnt, peak_count, LIST_CAP);
		$display("Statuses seen: ok %0d, bad index %0d, full %0d, not found %0d; mismatches %0d",
			status_seen[STAT_OK], status_seen[STAT_BAD_INDEX], status_seen[STAT_FULL],
			status_seen[STAT_NOT_FOUND], mismatch_cnt);
		if (mismatch_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
